// File: src/kbs_pkg.sv
// ----------------------------------------------------------------------------
// kbs_pkg: shared definitions for the keyed byte scrambler
// Constants of the scrambling scheme, configuration register indexes and
// the control and update bundles that pass between the top level and the
// byte transform.
// ----------------------------------------------------------------------------
package kbs_pkg;

  // Default width of the in-block byte position.
  localparam int unsigned POSITION_BITS_DEF = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned KEY_BITS   = KEY_WORDS * CFG_DATA_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd4;

  // Direction codes.
  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  // Scheme constants.
  localparam logic [7:0] FOLD_ADD  = 8'h3F;
  localparam logic [7:0] FIRST_XOR = 8'h59;
  localparam logic [7:0] CHAIN_XOR = 8'hBF;
  localparam logic [7:0] SKIP_XOR  = 8'hFE;
  localparam logic [7:0] SKIP_ADD  = 8'h6F;
  localparam logic [4:0] FIRST_KEY = 5'h17;

  // Per-byte control handed to the transform.
  typedef struct packed {
    logic       dir;      // direction of this byte
    logic       first;    // byte 0 of a block
    logic       skip;     // skip map applies at this position
    logic [4:0] key_idx;  // low position bits select the key byte
  } ctl_t;

  // Result of the transform for one byte.
  typedef struct packed {
    logic [7:0] result;   // output byte
    logic [7:0] chain;    // new chain value
    logic [2:0] stride;   // variable part of the next skip distance
  } upd_t;

endpackage

// File: src/kbs_if.sv
// ----------------------------------------------------------------------------
// kbs_in_if / kbs_out_if: valid/ready stream channels
// Input channel carries one data byte with its block start flag; output
// channel carries one result byte.
// ----------------------------------------------------------------------------
interface kbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

interface kbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

// File: src/kbs_xform.sv
// ----------------------------------------------------------------------------
// kbs_xform: single-byte scramble / unscramble
// Folds the selected key byte, applies the first-byte rotate or the chained
// nibble-swap step, and the skip map, in either direction.
// ----------------------------------------------------------------------------
module kbs_xform (
  input  logic [kbs_pkg::KEY_BITS-1:0] key_i,
  input  kbs_pkg::ctl_t                ctl_i,
  input  logic [7:0]                   data_i,
  input  logic [7:0]                   chain_i,
  output kbs_pkg::upd_t                upd_o
);

  logic [4:0] kidx;
  logic [4:0] hidx;
  logic [7:0] kraw;
  logic [7:0] khigh;
  logic [7:0] kbyte;
  logic [7:0] mix;
  logic [7:0] dec_a;
  logic [7:0] dec_rot;
  logic [7:0] dec_t;
  logic [7:0] dec_r;
  logic [7:0] enc_s;
  logic [7:0] enc_c;
  logic [7:0] enc_k;

  // Folded key byte: the first half is mixed with the second half.
  always_comb begin
    kidx  = ctl_i.first ? kbs_pkg::FIRST_KEY : ctl_i.key_idx;
    hidx  = {1'b1, kidx[3:0]};
    kraw  = key_i[8*kidx +: 8];
    khigh = key_i[8*hidx +: 8];
    kbyte = kidx[4] ? kraw : (kraw ^ (khigh + kbs_pkg::FOLD_ADD));
  end

  // Chain term: nibble swap of the previous plain-side value.
  always_comb begin
    mix = chain_i ^ kbs_pkg::CHAIN_XOR;
    mix = {mix[3:0], mix[7:4]};
  end

  // Decode path.
  always_comb begin
    dec_a   = data_i ^ kbs_pkg::FIRST_XOR;
    dec_rot = {dec_a[4:0], dec_a[7:5]};
    dec_t   = ctl_i.first ? (dec_rot ^ kbyte) : ((data_i + mix) ^ kbyte);
    dec_r   = ctl_i.skip ? ((dec_t ^ kbs_pkg::SKIP_XOR) + kbs_pkg::SKIP_ADD) : dec_t;
  end

  // Encode path.
  always_comb begin
    enc_s = ctl_i.skip ? ((data_i - kbs_pkg::SKIP_ADD) ^ kbs_pkg::SKIP_XOR) : data_i;
    enc_k = enc_s ^ kbyte;
    enc_c = {enc_k[2:0], enc_k[7:3]} ^ kbs_pkg::FIRST_XOR;
  end

  // Select by direction.
  always_comb begin
    if (ctl_i.dir == kbs_pkg::DIR_ENCODE) begin
      upd_o.result = ctl_i.first ? enc_c : (enc_k - mix);
      upd_o.chain  = ctl_i.first ? enc_k : enc_s;
      upd_o.stride = data_i[3:1];
    end else begin
      upd_o.result = dec_r;
      upd_o.chain  = ctl_i.first ? dec_rot : dec_t;
      upd_o.stride = dec_r[3:1];
    end
  end

endmodule

// File: src/keyed_byte_scrambler.sv
// ----------------------------------------------------------------------------
// keyed_byte_scrambler: keyed byte stream scrambler, top level
// Registers each input byte, transforms it in one pass against the chain,
// position and skip state, and holds the result in an output register.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                     Transfer when
//  in_chan  in   data_byte[7:0], block_start valid && ready
//  out_chan out  result_byte[7:0]            valid && ready
//  cfg      in   cfg_idx_i, cfg_wdata_i      cfg_we_i high
//
//  Input transfer reaches result valid through one input register and one
//  result register. One byte per cycle is sustained while the output is
//  taken; the limit is the chain value loop through the transform.
//  A stalled output holds its result while one more byte is taken into the
//  input register. Reset clears direction, key, chain, position and skip
//  state; there is no clearing pass.
//
module keyed_byte_scrambler #(
  parameter int unsigned POSITION_BITS = kbs_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kbs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kbs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  kbs_in_if.sink                           in_chan,
  kbs_out_if.source                        out_chan
);

  logic                                               dir_q;
  logic [kbs_pkg::KEY_WORDS-1:0][kbs_pkg::CFG_DATA_W-1:0] key_q;

  logic                     s1_valid_q;
  logic [7:0]               s1_data_q;
  logic                     s1_start_q;
  logic                     out_valid_q;
  logic [7:0]               res_q;

  logic [7:0]               chain_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] nsp_q;

  logic                     advance;
  logic                     compute;
  logic                     in_xfer;
  logic [POSITION_BITS-1:0] pos_cur;
  logic [POSITION_BITS-1:0] nsp_cur;
  kbs_pkg::ctl_t            ctl;
  kbs_pkg::upd_t            upd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= kbs_pkg::DIR_DECODE;
      key_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kbs_pkg::CFG_DIRECTION:  dir_q    <= cfg_wdata_i[0];
        kbs_pkg::CFG_KEY_WORD_0: key_q[0] <= cfg_wdata_i;
        kbs_pkg::CFG_KEY_WORD_1: key_q[1] <= cfg_wdata_i;
        kbs_pkg::CFG_KEY_WORD_2: key_q[2] <= cfg_wdata_i;
        kbs_pkg::CFG_KEY_WORD_3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow: the result register frees when empty or taken.
  assign advance       = !out_valid_q || out_chan.ready;
  assign compute       = s1_valid_q && advance;
  assign in_chan.ready = !s1_valid_q || advance;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // Position and skip state seen by the byte in the input register.
  always_comb begin
    pos_cur     = s1_start_q ? '0 : pos_q;
    nsp_cur     = (pos_cur == '0) ? '0 : nsp_q;
    ctl.dir     = dir_q;
    ctl.first   = (pos_cur == '0);
    ctl.skip    = (pos_cur == nsp_cur);
    ctl.key_idx = pos_cur[4:0];
  end

  kbs_xform u_xform (
    .key_i   (key_q),
    .ctl_i   (ctl),
    .data_i  (s1_data_q),
    .chain_i (chain_q),
    .upd_o   (upd)
  );

  // Valid flags and block state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
      pos_q       <= '0;
      nsp_q       <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_q <= in_chan.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (compute) begin
        chain_q <= upd.chain;
        pos_q   <= pos_cur + POSITION_BITS'(1);
        nsp_q   <= ctl.skip ? (pos_cur + POSITION_BITS'(4) + POSITION_BITS'(upd.stride))
                            : nsp_cur;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q  <= in_chan.data_byte;
      s1_start_q <= in_chan.block_start;
    end
    if (compute) begin
      res_q <= upd.result;
    end
  end

  assign out_chan.valid       = out_valid_q;
  assign out_chan.result_byte = res_q;

endmodule

// File: src/kbs_checker.sv
// ----------------------------------------------------------------------------
// kbs_checker: port-level checks for the keyed byte scrambler
// Watches the stream channels for result ordering against input transfers
// and for result hold under stall; bound to the top level.
// ----------------------------------------------------------------------------
module kbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i
);

  logic       in_xfer;
  logic       out_xfer;
  logic [2:0] flight_q;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Bytes accepted whose result has not been transferred yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      flight_q <= flight_q + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  // A result is never shown without a byte in flight.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (flight_q != 3'd0))
    else $error("result shown with no byte in flight");

  // At most two bytes are held inside the block.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flight_q == 3'd0) || (flight_q == 3'd1) || (flight_q == 3'd2))
    else $error("more than two bytes in flight");

  // An empty output register never blocks the input.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output register empty");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_byte_i)))
    else $error("stalled result changed or dropped");

endmodule

bind keyed_byte_scrambler kbs_checker u_kbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan.valid),
  .in_ready_i  (in_chan.ready),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .out_byte_i  (out_chan.result_byte)
);
